>>> hdl/sasmdu_pkg.sv
// sasmdu_pkg: types, constants and the microcode rom of the signed add/sub/mul/div unit
// no dependencies; used by signed_add_sub_mul_div_unit
package sasmdu_pkg;

  localparam int DATA_WIDTH = 64;
  localparam int PORT_WIDTH = 64;
  localparam int CNT_W      = $clog2(DATA_WIDTH + 1);
  localparam int UPC_W      = 4;

  typedef logic [UPC_W-1:0] upc_t;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_t;

  // datapath action of one microinstruction
  typedef enum logic [3:0] {
    ACT_LOAD,
    ACT_ADD,
    ACT_SUB,
    ACT_ABS_A,
    ACT_ABS_B,
    ACT_DIV_STEP,
    ACT_DIV_FIX,
    ACT_ZERO,
    ACT_MUL_INIT,
    ACT_MUL_STEP,
    ACT_OUT
  } act_t;

  // sequencing of one microinstruction
  typedef enum logic [2:0] {
    C_NEXT,      // fall through to the next address
    C_GOTO,      // jump to target
    C_DISPATCH,  // wait for a transfer, then jump by operation
    C_LOOP,      // jump to target until the bit counter runs out
    C_ZERO_B,    // jump to target when the divisor is zero
    C_WAIT       // hold until the output register is free, then jump to target
  } cond_t;

  typedef struct packed {
    act_t  act;
    cond_t cond;
    upc_t  target;
  } uword_t;

  // microcode addresses
  localparam upc_t U_IDLE     = 4'd0;
  localparam upc_t U_ADD      = 4'd1;
  localparam upc_t U_SUB      = 4'd2;
  localparam upc_t U_DIV_ABSA = 4'd3;
  localparam upc_t U_DIV_ABSB = 4'd4;
  localparam upc_t U_DIV_STEP = 4'd5;
  localparam upc_t U_DIV_FIX  = 4'd6;
  localparam upc_t U_ZERO     = 4'd7;
  localparam upc_t U_MUL_INIT = 4'd8;
  localparam upc_t U_MUL_STEP = 4'd9;
  localparam upc_t U_OUT      = 4'd10;

  function automatic uword_t urom(input upc_t addr);
    uword_t w;
    unique case (addr)
      U_IDLE:     w = '{ACT_LOAD,     C_DISPATCH, U_IDLE};
      U_ADD:      w = '{ACT_ADD,      C_GOTO,     U_OUT};
      U_SUB:      w = '{ACT_SUB,      C_GOTO,     U_OUT};
      U_DIV_ABSA: w = '{ACT_ABS_A,    C_ZERO_B,   U_ZERO};
      U_DIV_ABSB: w = '{ACT_ABS_B,    C_NEXT,     U_IDLE};
      U_DIV_STEP: w = '{ACT_DIV_STEP, C_LOOP,     U_DIV_STEP};
      U_DIV_FIX:  w = '{ACT_DIV_FIX,  C_GOTO,     U_OUT};
      U_ZERO:     w = '{ACT_ZERO,     C_GOTO,     U_OUT};
      U_MUL_INIT: w = '{ACT_MUL_INIT, C_NEXT,     U_IDLE};
      U_MUL_STEP: w = '{ACT_MUL_STEP, C_LOOP,     U_MUL_STEP};
      U_OUT:      w = '{ACT_OUT,      C_WAIT,     U_IDLE};
      default:    w = '{ACT_LOAD,     C_GOTO,     U_IDLE};
    endcase
    return w;
  endfunction

  // entry point of each operation
  function automatic upc_t dispatch(input op_t op);
    upc_t a;
    unique case (op)
      OP_ADD:  a = U_ADD;
      OP_SUB:  a = U_SUB;
      OP_MUL:  a = U_MUL_INIT;
      OP_DIV:  a = U_DIV_ABSA;
      default: a = U_IDLE;
    endcase
    return a;
  endfunction

endpackage

>>> hdl/signed_add_sub_mul_div_unit.sv
// Signed integer unit on DATA_WIDTH-bit two's complement words: add, subtract and
// multiply wrap to the low bits, divide truncates toward zero, divide by zero gives 0 and
// the most negative value over -1 gives the most negative value. A microprogram in a small
// rom steers one shared adder, a shift register pair and a restoring-divide subtractor.
// One item at a time: add and subtract pass through a single add step to the output step,
// multiply runs the one-bit-per-cycle shift-add loop over DATA_WIDTH bits, and divide
// runs the one-bit-per-cycle restoring loop between sign and fix-up steps (a zero divisor
// skips the loop). A new item is taken as soon as the sequencer is back in idle,
// even while the last result still sits in the output register.
// Depends on sasmdu_pkg.
module signed_add_sub_mul_div_unit
  import sasmdu_pkg::*;
(
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [1:0]                   operation,
  input  logic signed [PORT_WIDTH-1:0] operand_a,
  input  logic signed [PORT_WIDTH-1:0] operand_b,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic signed [PORT_WIDTH-1:0] result_value
);

  upc_t                  upc;
  upc_t                  upc_next;
  uword_t                uw;
  logic [DATA_WIDTH-1:0] xa;    // operand a, multiplier, dividend then quotient
  logic [DATA_WIDTH-1:0] xb;    // operand b, shifted multiplicand, divisor
  logic [DATA_WIDTH-1:0] acc;
  logic [DATA_WIDTH-1:0] rem;
  logic [CNT_W-1:0]      cnt;
  logic                  neg;

  logic                  in_accept;
  logic                  out_full;
  logic [DATA_WIDTH-1:0] add_x;
  logic [DATA_WIDTH-1:0] add_y;
  logic                  add_cin;
  logic [DATA_WIDTH-1:0] sum;
  logic [DATA_WIDTH+1:0] trial;

  assign uw        = urom(upc);
  assign in_stall  = (upc != U_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_full  = out_valid && out_stall;

  // shared adder
  always_comb begin
    add_x   = '0;
    add_y   = '0;
    add_cin = 1'b0;
    unique case (uw.act)
      ACT_ADD: begin
        add_x = xa;
        add_y = xb;
      end
      ACT_SUB: begin
        add_x   = xa;
        add_y   = ~xb;
        add_cin = 1'b1;
      end
      ACT_ABS_A: begin
        add_y   = ~xa;
        add_cin = 1'b1;
      end
      ACT_ABS_B: begin
        add_y   = ~xb;
        add_cin = 1'b1;
      end
      ACT_DIV_FIX: begin
        add_y   = neg ? ~xa : xa;
        add_cin = neg;
      end
      ACT_MUL_STEP: begin
        add_x = acc;
        add_y = xb;
      end
      default: begin
        add_x = '0;
      end
    endcase
  end

  assign sum = add_x + add_y + DATA_WIDTH'(add_cin);

  // restoring divide: partial remainder shifted left with the next dividend bit, minus divisor
  assign trial = {1'b0, rem, xa[DATA_WIDTH-1]} - {2'b00, xb};

  always_comb begin
    upc_next = upc;
    unique case (uw.cond)
      C_NEXT:     upc_next = upc + 1'b1;
      C_GOTO:     upc_next = uw.target;
      C_DISPATCH: upc_next = in_accept ? dispatch(op_t'(operation)) : upc;
      C_LOOP:     upc_next = (cnt != CNT_W'(1)) ? uw.target : upc + 1'b1;
      C_ZERO_B:   upc_next = (xb == '0) ? uw.target : upc + 1'b1;
      C_WAIT:     upc_next = out_full ? upc : uw.target;
      default:    upc_next = U_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      upc       <= U_IDLE;
      out_valid <= 1'b0;
    end else begin
      upc <= upc_next;
      if (uw.act == ACT_OUT && !out_full) begin
        out_valid    <= 1'b1;
        result_value <= PORT_WIDTH'(signed'(acc));
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end

      unique case (uw.act)
        ACT_LOAD: begin
          if (in_accept) begin
            xa <= operand_a[DATA_WIDTH-1:0];
            xb <= operand_b[DATA_WIDTH-1:0];
          end
        end
        ACT_ADD, ACT_SUB: begin
          acc <= sum;
        end
        ACT_ABS_A: begin
          neg <= xa[DATA_WIDTH-1] ^ xb[DATA_WIDTH-1];
          if (xa[DATA_WIDTH-1]) begin
            xa <= sum;
          end
        end
        ACT_ABS_B: begin
          if (xb[DATA_WIDTH-1]) begin
            xb <= sum;
          end
          rem <= '0;
          cnt <= CNT_W'(DATA_WIDTH);
        end
        ACT_DIV_STEP: begin
          if (!trial[DATA_WIDTH+1]) begin
            rem <= trial[DATA_WIDTH-1:0];
          end else begin
            rem <= {rem[DATA_WIDTH-2:0], xa[DATA_WIDTH-1]};
          end
          xa  <= {xa[DATA_WIDTH-2:0], ~trial[DATA_WIDTH+1]};
          cnt <= cnt - 1'b1;
        end
        ACT_DIV_FIX: begin
          acc <= sum;
        end
        ACT_ZERO: begin
          acc <= '0;
        end
        ACT_MUL_INIT: begin
          acc <= '0;
          cnt <= CNT_W'(DATA_WIDTH);
        end
        ACT_MUL_STEP: begin
          if (xa[0]) begin
            acc <= sum;
          end
          xa  <= xa >> 1;
          xb  <= xb << 1;
          cnt <= cnt - 1'b1;
        end
        ACT_OUT: begin
          acc <= acc;
        end
        default: begin
          acc <= acc;
        end
      endcase
    end
  end

  // a transfer always enters one of the four operation entry points
  a_dispatch: assert property (@(posedge clk) disable iff (rst)
    in_accept |=> (upc == U_ADD || upc == U_SUB || upc == U_MUL_INIT || upc == U_DIV_ABSA))
    else $error("sequencer did not dispatch after a transfer");

  // bit loops never run with an exhausted counter
  a_loop_cnt: assert property (@(posedge clk) disable iff (rst)
    (upc == U_DIV_STEP || upc == U_MUL_STEP) |-> cnt != '0)
    else $error("bit loop running with zero count");

  // a new result only comes out of the output step
  a_out_src: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(upc) == U_OUT)
    else $error("result raised outside the output step");

  // once the output register takes the result the sequencer is free again
  a_back_idle: assert property (@(posedge clk) disable iff (rst)
    (upc == U_OUT && !out_full) |=> (upc == U_IDLE && out_valid))
    else $error("sequencer did not return to idle after output");

endmodule

>>> tb/sasmdu_checker.sv
// sasmdu_checker: watches both channels of signed_add_sub_mul_div_unit, predicts each result
// from the accepted operands and compares it with what comes out; depends on sasmdu_pkg
`timescale 1ns / 100ps

module sasmdu_checker
  import sasmdu_pkg::*;
(
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  input  logic                         in_stall,
  input  logic [1:0]                   operation,
  input  logic signed [PORT_WIDTH-1:0] operand_a,
  input  logic signed [PORT_WIDTH-1:0] operand_b,
  input  logic                         out_valid,
  input  logic                         out_stall,
  input  logic signed [PORT_WIDTH-1:0] result_value,
  output int                           fail_count,
  output int                           pending,
  output int                           checked
);

  typedef struct {
    op_t                   op;
    logic signed [63:0]    a;
    logic signed [63:0]    b;
    logic signed [63:0]    value;
  } alu_result_t;

  alu_result_t results_due[$];
  int          fails = 0;
  int          seen  = 0;

  // wrapped add/sub/mul, divide truncated toward zero on DATA_WIDTH-bit words
  function automatic logic [63:0] alu_value(input op_t op, input logic [63:0] a,
                                            input logic [63:0] b);
    logic [63:0] mask;
    logic [63:0] sign;
    logic [63:0] r;
    logic [63:0] mag_a;
    logic [63:0] mag_b;
    mask = ~64'd0 >> (64 - DATA_WIDTH);
    sign = 64'd1 << (DATA_WIDTH - 1);
    a = a & mask;
    b = b & mask;
    case (op)
      OP_ADD: r = (a + b) & mask;
      OP_SUB: r = (a - b) & mask;
      OP_MUL: r = (a * b) & mask;
      default: begin
        mag_a = ((a & sign) != 0) ? ((~a + 64'd1) & mask) : a;
        mag_b = ((b & sign) != 0) ? ((~b + 64'd1) & mask) : b;
        if (mag_b == 64'd0) begin
          r = 64'd0;
        end else begin
          // most negative over minus one lands back on the most negative value here
          r = mag_a / mag_b;
          if (((a ^ b) & sign) != 0)
            r = (~r + 64'd1) & mask;
        end
      end
    endcase
    if ((r & sign) != 0)
      r = r | ~mask;
    return r;
  endfunction

  always @(posedge clk) begin
    alu_result_t exp_item;
    alu_result_t head;
    if (!rst) begin
      if (in_valid && !in_stall) begin
        exp_item.op    = op_t'(operation);
        exp_item.a     = operand_a;
        exp_item.b     = operand_b;
        exp_item.value = alu_value(op_t'(operation), operand_a, operand_b);
        results_due.push_back(exp_item);
      end
      if (out_valid && !out_stall) begin
        seen++;
        if (results_due.size() == 0) begin
          fails++;
          $error("result transfer with nothing outstanding: result_value %0d", result_value);
        end else begin
          head = results_due.pop_front();
          if (result_value !== head.value) begin
            fails++;
            $error("result_value mismatch: expected %0d, actual %0d (%s a=%0d b=%0d)",
                   head.value, result_value, head.op.name(), head.a, head.b);
          end
        end
      end
    end
    fail_count <= fails;
    pending    <= results_due.size();
    checked    <= seen;
  end

endmodule

>>> tb/tb_top.sv
// tb_top: stimulus and verdict for signed_add_sub_mul_div_unit; directed corner cases then
// random items with random gaps and output stalls; depends on sasmdu_pkg and sasmdu_checker
`timescale 1ns / 100ps

module tb_top
  import sasmdu_pkg::*;
();

  localparam int          RANDOM_ITEMS = 1930;
  localparam int          CYCLE_LIMIT  = 1000000;
  localparam logic [63:0] MIN_VAL      = 64'h8000_0000_0000_0000;
  localparam logic [63:0] MAX_VAL      = 64'h7fff_ffff_ffff_ffff;
  localparam logic [63:0] MINUS_ONE    = 64'hffff_ffff_ffff_ffff;

  logic                         clk          = 1'b0;
  logic                         rst          = 1'b1;
  logic                         in_valid     = 1'b0;
  logic                         in_stall;
  logic [1:0]                   operation    = OP_ADD;
  logic signed [PORT_WIDTH-1:0] operand_a    = '0;
  logic signed [PORT_WIDTH-1:0] operand_b    = '0;
  logic                         out_valid;
  logic                         out_stall    = 1'b0;
  logic signed [PORT_WIDTH-1:0] result_value;

  logic calm        = 1'b0;
  int   cycle_count = 0;
  int   fail_count;
  int   pending;
  int   checked;
  int   directed_sent = 0;
  int   random_sent   = 0;

  signed_add_sub_mul_div_unit i_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .operation    (operation),
    .operand_a    (operand_a),
    .operand_b    (operand_b),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .result_value (result_value)
  );

  sasmdu_checker i_checker (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .operation    (operation),
    .operand_a    (operand_a),
    .operand_b    (operand_b),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .result_value (result_value),
    .fail_count   (fail_count),
    .pending      (pending),
    .checked      (checked)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $error("run did not finish within %0d cycles", CYCLE_LIMIT);
      $display("Some tests failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_stall <= !calm && ($urandom_range(99) < 31);
  end

  // mix of corner values, small numbers, full-width noise and random magnitudes
  function automatic logic [63:0] pick_operand();
    logic [63:0] v;
    case ($urandom_range(9))
      0: begin
        case ($urandom_range(4))
          0: v = MIN_VAL;
          1: v = MAX_VAL;
          2: v = 64'd0;
          3: v = 64'd1;
          default: v = MINUS_ONE;
        endcase
      end
      1, 2: v = 64'($signed($urandom_range(200)) - 100);
      3, 4, 5: v = {$urandom, $urandom};
      default: begin
        v = {$urandom, $urandom} >> $urandom_range(63);
        if ($urandom_range(1) == 1)
          v = -v;
      end
    endcase
    return v;
  endfunction

  // hold valid high across back-to-back transfers; drop it only inside a gap
  task automatic send_item(input op_t op, input logic [63:0] a, input logic [63:0] b,
                           input logic quiet);
    while (!quiet && $urandom_range(99) < 31) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    operation <= op;
    operand_a <= a;
    operand_b <= b;
    @(posedge clk);
    while (in_stall)
      @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0)
      @(posedge clk);
  endtask

  task automatic directed(input op_t op, input logic [63:0] a, input logic [63:0] b);
    send_item(op, a, b, 1'b0);
    directed_sent++;
  endtask

  initial begin
    op_t         op;
    logic [63:0] a;
    logic [63:0] b;
    logic        quiet;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // overflow wrap on add, subtract and multiply
    directed(OP_ADD, MAX_VAL, 64'd1);
    directed(OP_ADD, MIN_VAL, MIN_VAL);
    directed(OP_ADD, 64'd0, 64'd0);
    directed(OP_SUB, MIN_VAL, 64'd1);
    directed(OP_SUB, 64'd0, MIN_VAL);
    directed(OP_SUB, MINUS_ONE, MAX_VAL);
    directed(OP_MUL, MAX_VAL, MAX_VAL);
    directed(OP_MUL, MIN_VAL, MINUS_ONE);
    directed(OP_MUL, MIN_VAL, MIN_VAL);
    directed(OP_MUL, MINUS_ONE, MINUS_ONE);
    // divide: zero divisor, most negative over minus one, truncation and signs
    directed(OP_DIV, 64'd5, 64'd0);
    directed(OP_DIV, MIN_VAL, 64'd0);
    directed(OP_DIV, MIN_VAL, MINUS_ONE);
    directed(OP_DIV, MIN_VAL, 64'd1);
    directed(OP_DIV, -64'sd7, 64'd2);
    directed(OP_DIV, 64'd7, -64'sd2);
    directed(OP_DIV, MAX_VAL, MIN_VAL);
    directed(OP_DIV, MIN_VAL, MIN_VAL);
    directed(OP_DIV, MIN_VAL, MAX_VAL);
    directed(OP_DIV, 64'd0, -64'sd5);
    directed(OP_DIV, MAX_VAL, 64'd1);
    directed(OP_DIV, MINUS_ONE, MAX_VAL);
    directed(OP_DIV, 64'd100, 64'd7);
    drain();

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      quiet = (n >= 700 && n < 1000);
      calm <= quiet;
      if (n == 1300)
        drain();
      op = op_t'($urandom_range(3));
      a  = pick_operand();
      b  = pick_operand();
      if (op == OP_DIV && $urandom_range(15) == 0)
        b = 64'd0;
      send_item(op, a, b, quiet);
      random_sent++;
    end
    calm <= 1'b0;
    drain();
    repeat (80) @(posedge clk);

    $display("covered %0d directed and %0d random items over add, sub, mul and div,",
             directed_sent, random_sent);
    $display("with random input gaps and output stalls; %0d results checked", checked);
    if (pending != 0)
      $error("%0d expected results never arrived", pending);
    if (fail_count == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

>>> sim.f
hdl/sasmdu_pkg.sv
hdl/signed_add_sub_mul_div_unit.sv
tb/sasmdu_checker.sv
tb/tb_top.sv
